// ===== rtl/s2da_pkg.sv =====
// s2da_pkg: shared types, character codes and the powers-of-ten table
// for the signed integer to decimal ascii converter
// no dependencies

package s2da_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned TrialWidth = ValueWidth + 1;  // 8 * 10^9 needs 33 bits
    localparam int unsigned PosWidth   = 4;               // digit position 9 .. 0
    localparam int unsigned BitWidth   = 2;               // binary weight 8, 4, 2, 1

    localparam logic [PosWidth-1:0] TopPos   = PosWidth'(9);
    localparam logic [BitWidth-1:0] TopBit   = BitWidth'(3);
    localparam logic [CharWidth-1:0] CharZero  = 8'h30;  // '0'
    localparam logic [CharWidth-1:0] CharMinus = 8'h2d;  // '-'

    // word handed to the output register
    typedef struct packed {
        logic                 push;
        logic [CharWidth-1:0] character;
        logic                 last;
    } s2da_push_t;

    // result of one compare-subtract step
    typedef struct packed {
        logic                  ge;
        logic [ValueWidth-1:0] diff;
    } s2da_step_t;

    function automatic logic [TrialWidth-1:0] pow10(input logic [PosWidth-1:0] pos);
        logic [TrialWidth-1:0] p;
        case (pos)
            4'd0:    p = 33'd1;
            4'd1:    p = 33'd10;
            4'd2:    p = 33'd100;
            4'd3:    p = 33'd1000;
            4'd4:    p = 33'd10000;
            4'd5:    p = 33'd100000;
            4'd6:    p = 33'd1000000;
            4'd7:    p = 33'd10000000;
            4'd8:    p = 33'd100000000;
            4'd9:    p = 33'd1000000000;
            default: p = 33'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/s2da_sub_unit.sv =====
// s2da_sub_unit: shared compare-subtract unit, remainder against 10^pos * 2^bit
// depends on s2da_pkg

module s2da_sub_unit
    import s2da_pkg::*;
(
    input  logic [ValueWidth-1:0] rem,
    input  logic [PosWidth-1:0]   pos,
    input  logic [BitWidth-1:0]   wbit,
    output s2da_step_t            step
);

    logic [TrialWidth-1:0] trial;
    logic [TrialWidth-1:0] rem_ext;
    logic [TrialWidth-1:0] diff_full;

    assign trial     = pow10(pos) << wbit;
    assign rem_ext   = {1'b0, rem};
    assign diff_full = rem_ext - trial;

    assign step.ge   = (rem_ext >= trial);
    // only used when ge, so the top bit is zero then
    assign step.diff = diff_full[ValueWidth-1:0];

endmodule

// ===== rtl/s2da_out_reg.sv =====
// s2da_out_reg: single output register holding one character word
// depends on s2da_pkg

module s2da_out_reg
    import s2da_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  s2da_push_t           push,
    output logic                 can_push,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CharWidth-1:0] m_character,
    output logic                 m_last
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [CharWidth-1:0] char_reg;
    logic                 last_reg;

    assign can_push = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push.push && can_push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push && can_push) begin
            char_reg <= push.character;
            last_reg <= push.last;
        end
    end

    assign m_valid     = valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// signed_int_to_decimal_ascii: top level, sequencer around the shared
// compare-subtract unit; depends on s2da_pkg, s2da_sub_unit, s2da_out_reg
//
// channel   ports                          payload
// input     s_valid / s_ready              s_value[31:0] signed
// output    m_valid / m_ready              m_character[7:0], m_last
//
// a value is accepted, then converted in 40 steps, with one more step
// for the '-' of a negative value; the steps are set by the single
// compare-subtract unit: four binary steps per digit over ten digit
// positions. s_ready is high only while the sequencer is idle. each
// character waits in the output register; when it is still held the
// sequencer stalls on that step. reset is synchronous, active low.

module signed_int_to_decimal_ascii
    import s2da_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [ValueWidth-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [CharWidth-1:0]        m_character,
    output logic                        m_last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SIGN = 3'b010,
        ST_CONV = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [ValueWidth-1:0] rem_reg, rem_next;
    logic [PosWidth-1:0]   pos_reg, pos_next;
    logic [BitWidth-1:0]   bit_reg, bit_next;
    logic [3:0]            digit_reg, digit_next;
    logic                  started_reg, started_next;

    s2da_step_t            step;
    s2da_push_t            push;
    logic                  can_push;
    logic [ValueWidth-1:0] raw;
    logic [ValueWidth-1:0] mag;
    logic [3:0]            digit_final;
    logic                  emit;

    assign raw = ValueWidth'(s_value);
    assign mag = raw[ValueWidth-1] ? (ValueWidth'(0) - raw) : raw;

    s2da_sub_unit u_sub (
        .rem  (rem_reg),
        .pos  (pos_reg),
        .wbit (bit_reg),
        .step (step)
    );

    s2da_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .can_push    (can_push),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    // the compare result lands on the binary weight being tried
    assign digit_final = digit_reg | ({3'b000, step.ge} << bit_reg);
    // leading zeros are dropped, the units digit always goes out
    assign emit        = (digit_final != 4'd0) || started_reg || (pos_reg == 4'd0);

    always_comb begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        bit_next     = bit_reg;
        digit_next   = digit_reg;
        started_next = started_reg;
        push         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rem_next     = mag;
                    pos_next     = TopPos;
                    bit_next     = TopBit;
                    digit_next   = 4'd0;
                    started_next = 1'b0;
                    state_next   = raw[ValueWidth-1] ? ST_SIGN : ST_CONV;
                end
            end
            ST_SIGN: begin
                push.push      = 1'b1;
                push.character = CharMinus;
                push.last      = 1'b0;
                if (can_push) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bit_reg != '0) begin
                    if (step.ge) begin
                        rem_next = step.diff;
                    end
                    digit_next = digit_final;
                    bit_next   = bit_reg - 1'b1;
                end else begin
                    push.push      = emit;
                    push.character = CharZero + {4'b0000, digit_final};
                    push.last      = (pos_reg == 4'd0);
                    // hold the whole step while a digit cannot be handed over
                    if (!emit || can_push) begin
                        if (step.ge) begin
                            rem_next = step.diff;
                        end
                        digit_next   = 4'd0;
                        bit_next     = TopBit;
                        started_next = started_reg | emit;
                        if (pos_reg == 4'd0) begin
                            state_next = ST_IDLE;
                        end else begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        pos_reg     <= pos_next;
        bit_reg     <= bit_next;
        digit_reg   <= digit_next;
        started_reg <= started_next;
    end

`ifndef NO_ASSERTIONS
    // the remainder always fits below ten units of the current position
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && bit_reg == TopBit) |->
        ({4'b0000, rem_reg} < ({4'b0000, pow10(pos_reg)} * 37'd10)))
        else $error("remainder out of range for digit position");

    // a finished digit is a decimal digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && bit_reg == '0) |-> (digit_final <= 4'd9))
        else $error("digit above nine");

    // the units digit with room downstream ends the conversion
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && bit_reg == '0 && pos_reg == 4'd0 && can_push) |=>
        (state_reg == ST_IDLE && m_valid && m_last))
        else $error("conversion did not end on the units digit");

    // the sign word is never marked last
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN && can_push) |=>
        (m_valid && !m_last && m_character == CharMinus && state_reg == ST_CONV))
        else $error("sign word mishandled");
`endif

endmodule
